[rtl/tbsd_pkg.sv]
package tbsd_pkg;

    localparam int ID_W   = 3;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int POOL_W = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLIENT_ACQ = 3'd0;
    localparam logic [OP_W-1:0] OP_CLIENT_REL = 3'd1;
    localparam logic [OP_W-1:0] OP_COMP_ACQ   = 3'd2;
    localparam logic [OP_W-1:0] OP_COMP_REL   = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN      = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
    localparam logic [ST_W-1:0] STAT_HOLD_ALL  = 3'd1;
    localparam logic [ST_W-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [ST_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [ST_W-1:0] STAT_HOLD_NONE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [ID_W-1:0] buffer_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   buffer_id_res;
        logic [ST_W-1:0]   status;
        logic              last;
        logic [POOL_W-1:0] pool_size;
    } t_out_item;

    // queue operation requested from the datapath
    typedef enum logic [2:0] {
        Q_NONE,
        Q_INS_HEAD,
        Q_INS_TAIL,
        Q_TAKE_HEAD,
        Q_TAKE_TAIL
    } t_qop;

    typedef struct packed {
        t_qop            qop;
        logic            held_inc;
        logic            held_dec;
        logic            flag_set;
        logic            flag_clr;
        logic [ID_W-1:0] id;
    } t_dp_cmd;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic            count_one;
        logic            held_max;
        logic            held_zero;
        logic            flag;
        logic [ID_W-1:0] front_id;
        logic [ID_W-1:0] back_id;
    } t_dp_stat;

endpackage

[rtl/tbsd_datapath.sv]
module tbsd_datapath
    import tbsd_pkg::*;
#(
    parameter int POOL_SIZE = 3
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat
);

    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int HELD_W = $clog2(POOL_SIZE);

    logic [ID_W-1:0]   r_entries [POOL_SIZE];
    logic [ID_W-1:0]   n_entries [POOL_SIZE];
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [HELD_W-1:0] r_held,   n_held;
    logic              r_flag,   n_flag;
    logic [ID_W-1:0]   back_id;

    // entry at index count-1
    always_comb begin
        back_id = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (r_count == CNT_W'(i + 1)) begin
                back_id = r_entries[i];
            end
        end
    end

    always_comb begin
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count == CNT_W'(POOL_SIZE));
        o_stat.count_one = (r_count == CNT_W'(1));
        o_stat.held_max  = (r_held >= HELD_W'(POOL_SIZE - 1));
        o_stat.held_zero = (r_held == '0);
        o_stat.flag      = r_flag;
        o_stat.front_id  = r_entries[0];
        o_stat.back_id   = back_id;
    end

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        unique case (i_cmd.qop)
            Q_NONE: begin
            end
            Q_INS_HEAD: begin
                n_entries[0] = i_cmd.id;
                for (int i = 1; i < POOL_SIZE; i++) begin
                    n_entries[i] = r_entries[i - 1];
                end
                n_count = r_count + CNT_W'(1);
            end
            Q_INS_TAIL: begin
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (r_count == CNT_W'(i)) begin
                        n_entries[i] = i_cmd.id;
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
            Q_TAKE_HEAD: begin
                for (int i = 0; i < POOL_SIZE - 1; i++) begin
                    n_entries[i] = r_entries[i + 1];
                end
                n_count = r_count - CNT_W'(1);
            end
            Q_TAKE_TAIL: begin
                n_count = r_count - CNT_W'(1);
            end
            default: begin
            end
        endcase

        n_held = r_held;
        if (i_cmd.held_inc) begin
            n_held = r_held + HELD_W'(1);
        end else if (i_cmd.held_dec) begin
            n_held = r_held - HELD_W'(1);
        end

        n_flag = r_flag;
        if (i_cmd.flag_set) begin
            n_flag = 1'b1;
        end else if (i_cmd.flag_clr) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_entries[i] <= ID_W'(i);
            end
            r_count <= CNT_W'(POOL_SIZE);
            r_held  <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_entries <= n_entries;
            r_count   <= n_count;
            r_held    <= n_held;
            r_flag    <= n_flag;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POOL_SIZE))
        else $error("queue count above pool size");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(POOL_SIZE - 1))
        else $error("client holds too many buffers");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.qop == Q_TAKE_HEAD || i_cmd.qop == Q_TAKE_TAIL) |-> (r_count != '0))
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.qop == Q_INS_HEAD || i_cmd.qop == Q_INS_TAIL)
            |-> (r_count != CNT_W'(POOL_SIZE)))
        else $error("push into full queue");

endmodule

[rtl/tbsd_controller.sv]
module tbsd_controller
    import tbsd_pkg::*;
#(
    parameter int POOL_SIZE = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state    r_state,     n_state;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out,       n_out;
    logic      out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_RUN) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd       = '0;
        o_cmd.qop   = Q_NONE;
        o_cmd.id    = i_in_item.buffer_id;

        unique case (r_state)
            ST_RUN: begin
                if (i_in_valid && o_in_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    unique case (i_in_item.operation)
                        OP_CLIENT_ACQ: begin
                            if (i_stat.held_max) begin
                                n_out.status = STAT_HOLD_ALL;
                            end else if (i_stat.empty) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                o_cmd.qop           = Q_TAKE_TAIL;
                                o_cmd.held_inc      = 1'b1;
                                n_out.buffer_id_res = i_stat.back_id;
                            end
                        end
                        OP_CLIENT_REL: begin
                            if (i_stat.held_zero) begin
                                n_out.status = STAT_HOLD_NONE;
                            end else if (i_stat.full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                o_cmd.qop      = Q_INS_HEAD;
                                o_cmd.held_dec = 1'b1;
                                o_cmd.flag_set = 1'b1;
                            end
                        end
                        OP_COMP_ACQ: begin
                            if (i_stat.empty) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                o_cmd.qop           = Q_TAKE_HEAD;
                                o_cmd.flag_clr      = 1'b1;
                                n_out.buffer_id_res = i_stat.front_id;
                            end
                        end
                        OP_COMP_REL: begin
                            if (i_stat.full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                o_cmd.qop = i_stat.flag ? Q_INS_TAIL : Q_INS_HEAD;
                            end
                        end
                        OP_DRAIN: begin
                            n_out.pool_size = POOL_W'(POOL_SIZE);
                            if (i_stat.empty) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                o_cmd.qop           = Q_TAKE_TAIL;
                                n_out.buffer_id_res = i_stat.back_id;
                                n_out.last          = i_stat.count_one;
                                if (!i_stat.count_one) begin
                                    n_state = ST_DRAIN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    o_cmd.qop           = Q_TAKE_TAIL;
                    n_out_valid         = 1'b1;
                    n_out.buffer_id_res = i_stat.back_id;
                    n_out.status        = STAT_OK;
                    n_out.last          = i_stat.count_one;
                    n_out.pool_size     = POOL_W'(POOL_SIZE);
                    if (i_stat.count_one) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    a_drain_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> r_out_valid)
        else $error("draining without a pending result");

    a_not_last_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == ST_DRAIN))
        else $error("non-final result outside a drain");

    a_drain_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !o_in_ready)
        else $error("input taken during drain");

endmodule

[rtl/triple_buffer_swap_deque_unit.sv]
// Buffer handoff between a producing client and a displaying compositor. A
// small double-ended queue of buffer ids (POOL_SIZE entries, reset to ids 0 up
// to POOL_SIZE-1 from front to back) is managed by five operations: client
// acquire (take from the back), client release (put at the front, mark a newer
// frame), compositor acquire (take from the front, clear the mark), compositor
// release (back if a newer frame is marked, else front) and drain. Every
// operation except a drain of a non-empty queue answers with one result
// transaction, marked last. A drain answers with one result per queued id,
// back to front, and only the final one is marked last. Errors leave the
// state untouched and report a status code with a zero id. Timing: a single
// operation is taken and its result sits in an output register the next cycle;
// a new transaction is taken in the same cycle the previous result leaves, so
// back-to-back operations run at one per cycle when the sink keeps up and no
// drain is in progress. A drain of n ids pops one id per cycle from the queue
// registers while the sink keeps up; input stays held off from the cycle after
// the drain is taken until its final id is loaded, also while the sink stalls.
module triple_buffer_swap_deque_unit
    import tbsd_pkg::*;
#(
    parameter int POOL_SIZE = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input transaction channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    // result transaction channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // command and status between sequencer and queue datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // operation decode, error checks, drain sequencing and result register
    tbsd_controller #(
        .POOL_SIZE (POOL_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // queue registers, client hold count and newer-frame flag
    tbsd_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat)
    );

endmodule
